/* sv/dsc_pkg.sv */
`timescale 1ns / 1ps

package dsc_pkg;

   localparam int MIN_YEAR   = 1900;
   localparam int MAX_YEAR   = 2030;
   localparam int MONTHS     = 12;
   localparam int DAY_SECS   = 24 * 3600;
   localparam int HOUR_SECS  = 3600;
   localparam int MIN_SECS   = 60;
   localparam int YEAR_W     = 11;
   localparam int MON_W      = 4;
   localparam int ACC_W      = 36;
   localparam int CNT_W      = 33;

   // floor(y / 100) as (y * CENT_RECIP) >> CENT_SHIFT, exact for 11-bit years
   localparam int CENT_RECIP = 5243;
   localparam int CENT_SHIFT = 19;

   typedef logic signed [ACC_W-1:0] acc_type;

   // operation select codes on req_func
   typedef enum logic [2:0] {
      FUNC_TO_SECONDS   = 3'd0,
      FUNC_FROM_SECONDS = 3'd1,
      FUNC_ADD          = 3'd2,
      FUNC_SUBTRACT     = 3'd3,
      FUNC_COMPARE      = 3'd4,
      FUNC_DURATION     = 3'd5,
      FUNC_SPARE_6      = 3'd6,
      FUNC_SPARE_7      = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      OPD_YEAR,
      OPD_MONTH,
      OPD_DAY,
      OPD_HOUR,
      OPD_MINUTE,
      OPD_AMOUNT,
      OPD_SAVED
   } opd_sel_type;

   typedef struct packed {
      opd_sel_type        sel;
      logic [YEAR_W-1:0]  year;
      logic [MON_W-1:0]   month;
   } opd_req_type;

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [23:0]       prod;
      logic [4:0]        q;
      logic [YEAR_W-1:0] r;
      prod = 24'(y) * 24'(CENT_RECIP);
      q    = prod[CENT_SHIFT+4:CENT_SHIFT];
      r    = y - YEAR_W'(q) * YEAR_W'(100);
      return (r == '0) ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
   endfunction

   function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
      return is_leap(y) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_len(input logic [MON_W-1:0] m,
                                            input logic [YEAR_W-1:0] y);
      logic [4:0] len;
      unique case (m)
         4'd2: len = is_leap(y) ? 5'd29 : 5'd28;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         default: len = 5'd30;
      endcase
      return len;
   endfunction

endpackage

/* sv/dsc_operand.sv */
`timescale 1ns / 1ps

module dsc_operand import dsc_pkg::*; (
   input  opd_req_type          opd_req,
   input  logic signed [33:0]   amount,
   input  acc_type              saved,
   output acc_type              operand
);

   always_comb begin
      unique case (opd_req.sel)
         OPD_YEAR:   operand = acc_type'(year_len(opd_req.year)) * acc_type'(DAY_SECS);
         OPD_MONTH:  operand = acc_type'(month_len(opd_req.month, opd_req.year))
                               * acc_type'(DAY_SECS);
         OPD_DAY:    operand = acc_type'(DAY_SECS);
         OPD_HOUR:   operand = acc_type'(HOUR_SECS);
         OPD_MINUTE: operand = acc_type'(MIN_SECS);
         OPD_AMOUNT: operand = acc_type'(amount);
         OPD_SAVED:  operand = saved;
         default:    operand = '0;
      endcase
   end

endmodule

/* sv/dsc_alu.sv */
`timescale 1ns / 1ps

module dsc_alu import dsc_pkg::*; (
   input  acc_type  a,
   input  acc_type  b,
   input  logic     sub,
   output acc_type  result,
   output logic     ge
);

   // add or subtract; for a subtract, ge means a >= b (no overflow in range)
   assign result = sub ? (a - b) : (a + b);
   assign ge     = ~result[ACC_W-1];

endmodule

/* sv/datetime_seconds_converter_core.sv */
`timescale 1ns / 1ps

// Gregorian datetime unit, epoch 1 Jan 1900 00:00:00, years up to 2030.
// A word is taken when start is high and busy is low; busy then stays high
// until the result word appears on the rsp_ ports for one cycle with
// rsp_valid. The receiver cannot stall: the word must be taken in that cycle.
// All work goes through one 36-bit add/subtract unit, one step per cycle,
// so the latency follows the calendar walk. The steps of each operation:
//   to_seconds      walk the years and then the months of A
//   compare/duration  the same walk for A and then for B
//   from_seconds    peel off years, months, days, hours and minutes
//   add/subtract    to_seconds of A, combine with the amount, then from_seconds
//   unknown op      all fields zero
// A new word can be taken in the cycle that shows the result.
// Out-of-range datetime results give zero date and time with out_of_range.

module datetime_seconds_converter_core import dsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_func,
   input  logic [4:0]           req_day_a,
   input  logic [3:0]           req_month_a,
   input  logic [10:0]          req_year_a,
   input  logic [4:0]           req_hour_a,
   input  logic [5:0]           req_minute_a,
   input  logic [5:0]           req_second_a,
   input  logic [4:0]           req_day_b,
   input  logic [3:0]           req_month_b,
   input  logic [10:0]          req_year_b,
   input  logic [16:0]          req_time_b,
   input  logic signed [33:0]   req_amount,
   output logic                 rsp_valid,
   output logic [4:0]           rsp_day,
   output logic [3:0]           rsp_month,
   output logic [10:0]          rsp_year,
   output logic [4:0]           rsp_hour,
   output logic [5:0]           rsp_minute,
   output logic [5:0]           rsp_second,
   output logic signed [32:0]   rsp_seconds_count,
   output logic                 rsp_a_less_than_b,
   output logic                 rsp_a_greater_than_b,
   output logic                 rsp_a_equal_b,
   output logic                 rsp_out_of_range
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,  // waiting for a word
      ST_INIT = 11'b000_0000_0010,  // load day and time of day
      ST_YUP  = 11'b000_0000_0100,  // add whole years
      ST_MUP  = 11'b000_0000_1000,  // add whole months
      ST_COMB = 11'b000_0001_0000,  // combine with amount or with A
      ST_YDN  = 11'b000_0010_0000,  // peel off whole years
      ST_MDN  = 11'b000_0100_0000,  // peel off whole months
      ST_DDN  = 11'b000_1000_0000,  // peel off days
      ST_HDN  = 11'b001_0000_0000,  // peel off hours
      ST_NDN  = 11'b010_0000_0000,  // peel off minutes
      ST_DONE = 11'b100_0000_0000   // present the result word
   } state_type;

   // sequencer control
   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // operation and latched request
   func_type            func_ff, func_in;
   logic                pass_b_ff, pass_b_in;
   logic [4:0]          day_a_ff, day_a_in;
   logic [3:0]          month_a_ff, month_a_in;
   logic [10:0]         year_a_ff, year_a_in;
   logic [4:0]          hour_a_ff, hour_a_in;
   logic [5:0]          minute_a_ff, minute_a_in;
   logic [5:0]          second_a_ff, second_a_in;
   logic [4:0]          day_b_ff, day_b_in;
   logic [3:0]          month_b_ff, month_b_in;
   logic [10:0]         year_b_ff, year_b_in;
   logic [16:0]         time_b_ff, time_b_in;
   logic signed [33:0]  amount_ff, amount_in;

   // working registers
   acc_type             acc_ff, acc_in;       // running seconds
   acc_type             sa_ff, sa_in;         // seconds of A while B is built
   logic [YEAR_W-1:0]   y_ff, y_in;           // year walker
   logic [MON_W-1:0]    m_ff, m_in;           // month walker
   logic [4:0]          cnt_day_ff, cnt_day_in;
   logic [4:0]          cnt_hour_ff, cnt_hour_in;
   logic [5:0]          cnt_min_ff, cnt_min_in;

   // result word
   logic [4:0]          rsp_day_ff, rsp_day_in;
   logic [3:0]          rsp_month_ff, rsp_month_in;
   logic [10:0]         rsp_year_ff, rsp_year_in;
   logic [4:0]          rsp_hour_ff, rsp_hour_in;
   logic [5:0]          rsp_minute_ff, rsp_minute_in;
   logic [5:0]          rsp_second_ff, rsp_second_in;
   logic signed [32:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_lt_ff, rsp_lt_in;
   logic                rsp_gt_ff, rsp_gt_in;
   logic                rsp_eq_ff, rsp_eq_in;
   logic                rsp_oor_ff, rsp_oor_in;

   // shared unit hookup
   opd_req_type         opd_req;
   acc_type             operand;
   acc_type             alu_res;
   logic                alu_sub;
   logic                alu_ge;

   // date being built: A first, then B for compare and duration
   logic [YEAR_W-1:0]   yr_sel;
   logic [MON_W-1:0]    mon_sel;
   logic [4:0]          day_sel;
   logic [16:0]         tod_a;
   logic [16:0]         tod_sel;
   acc_type             init_val;

   function automatic logic signed [CNT_W-1:0] sat_count(input acc_type v);
      logic [ACC_W-CNT_W:0] top;
      top = v[ACC_W-1:CNT_W-1];
      if (!v[ACC_W-1] && (top != '0)) begin
         return {1'b0, {(CNT_W-1){1'b1}}};
      end else if (v[ACC_W-1] && (top != '1)) begin
         return {1'b1, {(CNT_W-1){1'b0}}};
      end else begin
         return v[CNT_W-1:0];
      end
   endfunction

   assign tod_a   = 17'(hour_a_ff) * 17'(HOUR_SECS) + 17'(minute_a_ff) * 17'(MIN_SECS)
                  + 17'(second_a_ff);
   assign yr_sel  = pass_b_ff ? year_b_ff  : year_a_ff;
   assign mon_sel = pass_b_ff ? month_b_ff : month_a_ff;
   assign day_sel = pass_b_ff ? day_b_ff   : day_a_ff;
   assign tod_sel = pass_b_ff ? time_b_ff  : tod_a;
   // day 0 counts as minus one day
   assign init_val = acc_type'(tod_sel) + acc_type'(day_sel) * acc_type'(DAY_SECS)
                   - acc_type'(DAY_SECS);

   dsc_operand u_operand (
      .opd_req (opd_req),
      .amount  (amount_ff),
      .saved   (sa_ff),
      .operand (operand)
   );

   dsc_alu u_alu (
      .a      (acc_ff),
      .b      (operand),
      .sub    (alu_sub),
      .result (alu_res),
      .ge     (alu_ge)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      func_in       = func_ff;
      pass_b_in     = pass_b_ff;
      day_a_in      = day_a_ff;
      month_a_in    = month_a_ff;
      year_a_in     = year_a_ff;
      hour_a_in     = hour_a_ff;
      minute_a_in   = minute_a_ff;
      second_a_in   = second_a_ff;
      day_b_in      = day_b_ff;
      month_b_in    = month_b_ff;
      year_b_in     = year_b_ff;
      time_b_in     = time_b_ff;
      amount_in     = amount_ff;
      acc_in        = acc_ff;
      sa_in         = sa_ff;
      y_in          = y_ff;
      m_in          = m_ff;
      cnt_day_in    = cnt_day_ff;
      cnt_hour_in   = cnt_hour_ff;
      cnt_min_in    = cnt_min_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_second_in = rsp_second_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_lt_in     = rsp_lt_ff;
      rsp_gt_in     = rsp_gt_ff;
      rsp_eq_in     = rsp_eq_ff;
      rsp_oor_in    = rsp_oor_ff;

      // year for month lengths: the target year while building, else the walker
      opd_req.sel   = OPD_DAY;
      opd_req.year  = (state_ff == ST_MUP) ? yr_sel : y_ff;
      opd_req.month = m_ff;
      alu_sub       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in       = func_type'(req_func);
               pass_b_in     = 1'b0;
               day_a_in      = req_day_a;
               month_a_in    = req_month_a;
               year_a_in     = req_year_a;
               hour_a_in     = req_hour_a;
               minute_a_in   = req_minute_a;
               second_a_in   = req_second_a;
               day_b_in      = req_day_b;
               month_b_in    = req_month_b;
               year_b_in     = req_year_b;
               time_b_in     = req_time_b;
               amount_in     = req_amount;
               acc_in        = acc_type'(req_amount);
               y_in          = YEAR_W'(MIN_YEAR);
               m_in          = MON_W'(1);
               // fields an operation does not produce stay zero
               rsp_day_in    = '0;
               rsp_month_in  = '0;
               rsp_year_in   = '0;
               rsp_hour_in   = '0;
               rsp_minute_in = '0;
               rsp_second_in = '0;
               rsp_count_in  = '0;
               rsp_lt_in     = 1'b0;
               rsp_gt_in     = 1'b0;
               rsp_eq_in     = 1'b0;
               rsp_oor_in    = 1'b0;
               unique case (req_func)
                  FUNC_FROM_SECONDS: state_in = ST_YDN;
                  FUNC_TO_SECONDS, FUNC_ADD, FUNC_SUBTRACT,
                  FUNC_COMPARE, FUNC_DURATION: state_in = ST_INIT;
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_INIT: begin
            acc_in   = init_val;
            y_in     = YEAR_W'(MIN_YEAR);
            m_in     = MON_W'(1);
            state_in = ST_YUP;
         end

         ST_YUP: begin
            opd_req.sel = OPD_YEAR;
            alu_sub     = 1'b0;
            if (y_ff < yr_sel) begin
               acc_in = alu_res;
               y_in   = y_ff + YEAR_W'(1);
            end else begin
               state_in = ST_MUP;
            end
         end

         ST_MUP: begin
            opd_req.sel = OPD_MONTH;
            alu_sub     = 1'b0;
            if (m_ff < mon_sel) begin
               acc_in = alu_res;
               m_in   = m_ff + MON_W'(1);
            end else begin
               state_in = ST_COMB;
            end
         end

         ST_COMB: begin
            unique case (func_ff)
               FUNC_TO_SECONDS: begin
                  rsp_count_in = sat_count(acc_ff);
                  state_in     = ST_DONE;
               end
               FUNC_ADD, FUNC_SUBTRACT: begin
                  opd_req.sel = OPD_AMOUNT;
                  alu_sub     = (func_ff == FUNC_SUBTRACT);
                  acc_in      = alu_res;
                  y_in        = YEAR_W'(MIN_YEAR);
                  m_in        = MON_W'(1);
                  state_in    = ST_YDN;
               end
               FUNC_COMPARE, FUNC_DURATION: begin
                  if (!pass_b_ff) begin
                     sa_in     = acc_ff;
                     pass_b_in = 1'b1;
                     state_in  = ST_INIT;
                  end else begin
                     // B minus A drives both the flags and the duration
                     opd_req.sel = OPD_SAVED;
                     if (func_ff == FUNC_COMPARE) begin
                        rsp_lt_in = !alu_res[ACC_W-1] && (alu_res != '0);
                        rsp_gt_in = alu_res[ACC_W-1];
                        rsp_eq_in = (alu_res == '0);
                     end else begin
                        rsp_count_in = sat_count(alu_res);
                     end
                     state_in = ST_DONE;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end

         ST_YDN: begin
            opd_req.sel = OPD_YEAR;
            // negative only on entry: before the epoch
            if (acc_ff[ACC_W-1] || (y_ff > YEAR_W'(MAX_YEAR))) begin
               rsp_oor_in = 1'b1;
               state_in   = ST_DONE;
            end else if (alu_ge) begin
               acc_in = alu_res;
               y_in   = y_ff + YEAR_W'(1);
            end else begin
               m_in     = MON_W'(1);
               state_in = ST_MDN;
            end
         end

         ST_MDN: begin
            opd_req.sel = OPD_MONTH;
            if ((m_ff < MON_W'(MONTHS)) && alu_ge) begin
               acc_in = alu_res;
               m_in   = m_ff + MON_W'(1);
            end else begin
               cnt_day_in = 5'd1;
               state_in   = ST_DDN;
            end
         end

         ST_DDN: begin
            opd_req.sel = OPD_DAY;
            if (alu_ge) begin
               acc_in     = alu_res;
               cnt_day_in = cnt_day_ff + 5'd1;
            end else begin
               cnt_hour_in = '0;
               state_in    = ST_HDN;
            end
         end

         ST_HDN: begin
            opd_req.sel = OPD_HOUR;
            if (alu_ge) begin
               acc_in      = alu_res;
               cnt_hour_in = cnt_hour_ff + 5'd1;
            end else begin
               cnt_min_in = '0;
               state_in   = ST_NDN;
            end
         end

         ST_NDN: begin
            opd_req.sel = OPD_MINUTE;
            if (alu_ge) begin
               acc_in     = alu_res;
               cnt_min_in = cnt_min_ff + 6'd1;
            end else begin
               rsp_day_in    = cnt_day_ff;
               rsp_month_in  = m_ff;
               rsp_year_in   = y_ff;
               rsp_hour_in   = cnt_hour_ff;
               rsp_minute_in = cnt_min_ff;
               rsp_second_in = acc_ff[5:0];
               state_in      = ST_DONE;
            end
         end

         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pass_b_ff     <= pass_b_in;
      day_a_ff      <= day_a_in;
      month_a_ff    <= month_a_in;
      year_a_ff     <= year_a_in;
      hour_a_ff     <= hour_a_in;
      minute_a_ff   <= minute_a_in;
      second_a_ff   <= second_a_in;
      day_b_ff      <= day_b_in;
      month_b_ff    <= month_b_in;
      year_b_ff     <= year_b_in;
      time_b_ff     <= time_b_in;
      amount_ff     <= amount_in;
      acc_ff        <= acc_in;
      sa_ff         <= sa_in;
      y_ff          <= y_in;
      m_ff          <= m_in;
      cnt_day_ff    <= cnt_day_in;
      cnt_hour_ff   <= cnt_hour_in;
      cnt_min_ff    <= cnt_min_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_second_ff <= rsp_second_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_lt_ff     <= rsp_lt_in;
      rsp_gt_ff     <= rsp_gt_in;
      rsp_eq_ff     <= rsp_eq_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_day              = rsp_day_ff;
   assign rsp_month            = rsp_month_ff;
   assign rsp_year             = rsp_year_ff;
   assign rsp_hour             = rsp_hour_ff;
   assign rsp_minute           = rsp_minute_ff;
   assign rsp_second           = rsp_second_ff;
   assign rsp_seconds_count    = rsp_count_ff;
   assign rsp_a_less_than_b    = rsp_lt_ff;
   assign rsp_a_greater_than_b = rsp_gt_ff;
   assign rsp_a_equal_b        = rsp_eq_ff;
   assign rsp_out_of_range     = rsp_oor_ff;

   // a result word is a single-cycle strobe
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a taken word keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after taking a word");

   // the result word is shown only once the sequencer is back at rest
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // out of range clears the date and time
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_day == '0 && rsp_month == '0 &&
                                           rsp_year == '0 && rsp_hour == '0 &&
                                           rsp_minute == '0 && rsp_second == '0))
      else $error("out-of-range result with nonzero datetime");

   // at most one compare flag
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_a_less_than_b, rsp_a_greater_than_b, rsp_a_equal_b}))
      else $error("more than one compare flag set");

endmodule

/* bench/datetime_seconds_converter_core_tb.sv */
`timescale 1ns / 1ps

module datetime_seconds_converter_core_tb import dsc_pkg::*; ();

   // one request word, one field per req_ port
   typedef struct {
      func_type          func;
      bit [4:0]          day_a;
      bit [3:0]          month_a;
      bit [10:0]         year_a;
      bit [4:0]          hour_a;
      bit [5:0]          minute_a;
      bit [5:0]          second_a;
      bit [4:0]          day_b;
      bit [3:0]          month_b;
      bit [10:0]         year_b;
      bit [16:0]         time_b;
      bit signed [33:0]  amount;
   } dt_word_type;

   // one response word as the block should give it
   typedef struct packed {
      bit [4:0]   day;
      bit [3:0]   month;
      bit [10:0]  year;
      bit [4:0]   hour;
      bit [5:0]   minute;
      bit [5:0]   second;
      bit [32:0]  count;
      bit         less;
      bit         greater;
      bit         equal;
      bit         out_of_range;
   } dt_result_type;

   localparam int WORDS_PER_PHASE = 370;
   localparam int PHASES          = 5;
   localparam int END_PAUSE       = 500;       // above the longest add/subtract walk
   localparam int TIMEOUT_NS      = 40_000_000;

   // sender idle percentage per phase: none, heavy, light, none, heavy
   localparam int unsigned IDLE_PCT [PHASES] = '{0, 81, 14, 0, 81};

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [2:0]          req_func;
   logic [4:0]          req_day_a;
   logic [3:0]          req_month_a;
   logic [10:0]         req_year_a;
   logic [4:0]          req_hour_a;
   logic [5:0]          req_minute_a;
   logic [5:0]          req_second_a;
   logic [4:0]          req_day_b;
   logic [3:0]          req_month_b;
   logic [10:0]         req_year_b;
   logic [16:0]         req_time_b;
   logic signed [33:0]  req_amount;
   logic                rsp_valid;
   logic [4:0]          rsp_day;
   logic [3:0]          rsp_month;
   logic [10:0]         rsp_year;
   logic [4:0]          rsp_hour;
   logic [5:0]          rsp_minute;
   logic [5:0]          rsp_second;
   logic signed [32:0]  rsp_seconds_count;
   logic                rsp_a_less_than_b;
   logic                rsp_a_greater_than_b;
   logic                rsp_a_equal_b;
   logic                rsp_out_of_range;

   dt_word_type    request_q[$];      // words waiting to be sent
   dt_result_type  conversion_q[$];   // predicted responses, oldest first
   int unsigned    sender_idle_pct;
   int             mismatch_count;
   longint         span_secs;         // seconds from the epoch to 1 Jan after the last year

   datetime_seconds_converter_core dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_func             (req_func),
      .req_day_a            (req_day_a),
      .req_month_a          (req_month_a),
      .req_year_a           (req_year_a),
      .req_hour_a           (req_hour_a),
      .req_minute_a         (req_minute_a),
      .req_second_a         (req_second_a),
      .req_day_b            (req_day_b),
      .req_month_b          (req_month_b),
      .req_year_b           (req_year_b),
      .req_time_b           (req_time_b),
      .req_amount           (req_amount),
      .rsp_valid            (rsp_valid),
      .rsp_day              (rsp_day),
      .rsp_month            (rsp_month),
      .rsp_year             (rsp_year),
      .rsp_hour             (rsp_hour),
      .rsp_minute           (rsp_minute),
      .rsp_second           (rsp_second),
      .rsp_seconds_count    (rsp_seconds_count),
      .rsp_a_less_than_b    (rsp_a_less_than_b),
      .rsp_a_greater_than_b (rsp_a_greater_than_b),
      .rsp_a_equal_b        (rsp_a_equal_b),
      .rsp_out_of_range     (rsp_out_of_range)
   );

   // ---------------------------------------------------------------
   // calendar arithmetic for the prediction
   // ---------------------------------------------------------------

   // gregorian rule: every 400th year leap, other centuries not, else every 4th
   function automatic bit leap_year(input longint y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   // months above 12 and month 0 fall to the 30-day default
   function automatic longint days_in_month(input longint m, input longint y);
      if (m == 2) return leap_year(y) ? 29 : 28;
      if (m == 1 || m == 3 || m == 5 || m == 7 || m == 8 || m == 10 || m == 12) return 31;
      return 30;
   endfunction

   function automatic longint days_in_year(input longint y);
      return leap_year(y) ? 366 : 365;
   endfunction

   // plain weighted sum, no range check: day 0 gives minus a day,
   // years below the epoch add nothing
   function automatic longint datetime_to_secs(input longint day, input longint month,
                                               input longint year, input longint tod);
      longint t;
      t = tod + (day - 1) * DAY_SECS;
      for (longint i = 1; i < month; i++) t += days_in_month(i, year) * DAY_SECS;
      for (longint i = MIN_YEAR; i < year; i++) t += days_in_year(i) * DAY_SECS;
      return t;
   endfunction

   // walk years then months; anything before the epoch or past the
   // last year gives a zero datetime with the range flag
   function automatic dt_result_type calendar_from_secs(input longint n);
      dt_result_type r;
      longint        y;
      longint        m;
      r = '0;
      y = MIN_YEAR;
      m = 1;
      if (n < 0) begin
         r.out_of_range = 1'b1;
         return r;
      end
      while (y <= MAX_YEAR && n >= days_in_year(y) * DAY_SECS) begin
         n -= days_in_year(y) * DAY_SECS;
         y++;
      end
      if (y > MAX_YEAR) begin
         r.out_of_range = 1'b1;
         return r;
      end
      while (m < MONTHS && n >= days_in_month(m, y) * DAY_SECS) begin
         n -= days_in_month(m, y) * DAY_SECS;
         m++;
      end
      r.day    = 5'(n / DAY_SECS + 1);
      n        = n % DAY_SECS;
      r.month  = 4'(m);
      r.year   = 11'(y);
      r.hour   = 5'(n / HOUR_SECS);
      r.minute = 6'((n / MIN_SECS) % MIN_SECS);
      r.second = 6'(n % MIN_SECS);
      return r;
   endfunction

   // saturate to the 33-bit signed count
   function automatic bit [32:0] clamp_count(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< 32) - 1;
      lo = -(longint'(1) <<< 32);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return 33'(v);
   endfunction

   function automatic dt_result_type predict_conversion(input dt_word_type w);
      dt_result_type r;
      longint        tod_a;
      longint        sa;
      longint        sb;
      longint        amt;
      r     = '0;
      tod_a = longint'(w.hour_a) * HOUR_SECS + longint'(w.minute_a) * MIN_SECS
              + longint'(w.second_a);
      sa    = datetime_to_secs(w.day_a, w.month_a, w.year_a, tod_a);
      sb    = datetime_to_secs(w.day_b, w.month_b, w.year_b, w.time_b);
      amt   = w.amount;
      case (w.func)
         FUNC_TO_SECONDS:   r.count = clamp_count(sa);
         FUNC_FROM_SECONDS: r = calendar_from_secs(amt);
         FUNC_ADD:          r = calendar_from_secs(sa + amt);
         FUNC_SUBTRACT:     r = calendar_from_secs(sa - amt);
         FUNC_COMPARE: begin
            r.less    = sa < sb;
            r.greater = sa > sb;
            r.equal   = sa == sb;
         end
         FUNC_DURATION:     r.count = clamp_count(sb - sa);
         default:           r = '0;   // spare codes give an all-zero word
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   function automatic dt_word_type make_word(input func_type op,
                                             input int d, input int m, input int y,
                                             input int h, input int mi, input int s,
                                             input int db, input int mb, input int yb,
                                             input int tb, input longint amt);
      dt_word_type w;
      w.func     = op;
      w.day_a    = 5'(d);
      w.month_a  = 4'(m);
      w.year_a   = 11'(y);
      w.hour_a   = 5'(h);
      w.minute_a = 6'(mi);
      w.second_a = 6'(s);
      w.day_b    = 5'(db);
      w.month_b  = 4'(mb);
      w.year_b   = 11'(yb);
      w.time_b   = 17'(tb);
      w.amount   = 34'(amt);
      return w;
   endfunction

   // valid calendar date, leaning on the epoch year, the last year,
   // the 2000 leap century and month ends
   function automatic void pick_date(output bit [4:0] d, output bit [3:0] m,
                                     output bit [10:0] y);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 5)       y = 11'(MIN_YEAR);
      else if (sel < 10) y = 11'(MAX_YEAR);
      else if (sel < 14) y = 11'd2000;
      else               y = 11'($urandom_range(MIN_YEAR, MAX_YEAR));
      m = 4'($urandom_range(1, MONTHS));
      if ($urandom_range(0, 99) < 15) d = 5'(days_in_month(m, y));
      else                            d = 5'($urandom_range(1, days_in_month(m, y)));
   endfunction

   function automatic dt_word_type random_word();
      dt_word_type w;
      int unsigned sel;
      longint      tod_a;
      longint      sa;
      longint      target;
      if ($urandom_range(0, 99) < 4) w.func = func_type'(3'($urandom_range(6, 7)));
      else                           w.func = func_type'(3'($urandom_range(0, 5)));
      pick_date(w.day_a, w.month_a, w.year_a);
      w.hour_a   = 5'($urandom_range(0, 23));
      w.minute_a = 6'($urandom_range(0, 59));
      w.second_a = 6'($urandom_range(0, 59));
      pick_date(w.day_b, w.month_b, w.year_b);
      w.time_b   = 17'($urandom_range(0, DAY_SECS - 1));
      tod_a = longint'(w.hour_a) * HOUR_SECS + longint'(w.minute_a) * MIN_SECS
              + longint'(w.second_a);
      sa    = datetime_to_secs(w.day_a, w.month_a, w.year_a, tod_a);

      // b on top of a or one second off, so compare hits equality
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         w.day_b   = w.day_a;
         w.month_b = w.month_a;
         w.year_b  = w.year_a;
         w.time_b  = 17'(tod_a);
         if (sel < 12) w.time_b = (tod_a == 0) ? 17'd1 : 17'(tod_a - 1);
      end

      // amount: short hops, anywhere in range, right at the range edges,
      // or raw 34-bit noise
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         w.amount = 34'(longint'($urandom_range(0, 20 * DAY_SECS)) - 10 * DAY_SECS);
      end else if (sel < 55) begin
         target = $urandom_range(0, 32'(span_secs - 1));
         if (w.func == FUNC_FROM_SECONDS) w.amount = 34'(target);
         else if ($urandom_range(0, 1))   w.amount = 34'(target);
         else                             w.amount = 34'(-target);
      end else if (sel < 75) begin
         target = ($urandom_range(0, 1) ? span_secs : 0) + $urandom_range(0, 4) - 2;
         if (w.func == FUNC_ADD)           w.amount = 34'(target - sa);
         else if (w.func == FUNC_SUBTRACT) w.amount = 34'(sa - target);
         else                              w.amount = 34'(target);
      end else begin
         w.amount = {2'($urandom), 32'($urandom)};
      end

      // malformed fields: raw bits across the full port width
      if ($urandom_range(0, 99) < 12) begin
         if ($urandom_range(0, 1)) w.day_a    = 5'($urandom);
         if ($urandom_range(0, 1)) w.month_a  = 4'($urandom);
         if ($urandom_range(0, 1)) w.year_a   = 11'($urandom);
         if ($urandom_range(0, 1)) w.hour_a   = 5'($urandom);
         if ($urandom_range(0, 1)) w.minute_a = 6'($urandom);
         if ($urandom_range(0, 1)) w.second_a = 6'($urandom);
         if ($urandom_range(0, 1)) w.day_b    = 5'($urandom);
         if ($urandom_range(0, 1)) w.month_b  = 4'($urandom);
         if ($urandom_range(0, 1)) w.year_b   = 11'($urandom);
         if ($urandom_range(0, 1)) w.time_b   = 17'($urandom);
      end
      return w;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // driver: presents the next pending word when the port is free
   // and the sender is not idling; a presented word is held until
   // taken, so its prediction is queued when it goes out
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_words
      dt_word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         // either nothing was offered or the offered word was taken at this edge
         if (request_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            w = request_q.pop_front();
            req_func     <= w.func;
            req_day_a    <= w.day_a;
            req_month_a  <= w.month_a;
            req_year_a   <= w.year_a;
            req_hour_a   <= w.hour_a;
            req_minute_a <= w.minute_a;
            req_second_a <= w.second_a;
            req_day_b    <= w.day_b;
            req_month_b  <= w.month_b;
            req_year_b   <= w.year_b;
            req_time_b   <= w.time_b;
            req_amount   <= w.amount;
            start        <= 1'b1;
            conversion_q.push_back(predict_conversion(w));
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: every strobed response word against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_words
      dt_result_type want;
      if (!reset && rsp_valid) begin
         if (conversion_q.size() == 0) begin
            flag_mismatch("response word with nothing pending, count",
                          longint'(rsp_seconds_count), 0);
         end else begin
            want = conversion_q.pop_front();
            if (rsp_day !== want.day)
               flag_mismatch("day", rsp_day, want.day);
            if (rsp_month !== want.month)
               flag_mismatch("month", rsp_month, want.month);
            if (rsp_year !== want.year)
               flag_mismatch("year", rsp_year, want.year);
            if (rsp_hour !== want.hour)
               flag_mismatch("hour", rsp_hour, want.hour);
            if (rsp_minute !== want.minute)
               flag_mismatch("minute", rsp_minute, want.minute);
            if (rsp_second !== want.second)
               flag_mismatch("second", rsp_second, want.second);
            if (rsp_seconds_count !== want.count)
               flag_mismatch("seconds_count", longint'(rsp_seconds_count),
                             longint'($signed(want.count)));
            if (rsp_a_less_than_b !== want.less)
               flag_mismatch("a_less_than_b", rsp_a_less_than_b, want.less);
            if (rsp_a_greater_than_b !== want.greater)
               flag_mismatch("a_greater_than_b", rsp_a_greater_than_b, want.greater);
            if (rsp_a_equal_b !== want.equal)
               flag_mismatch("a_equal_b", rsp_a_equal_b, want.equal);
            if (rsp_out_of_range !== want.out_of_range)
               flag_mismatch("out_of_range", rsp_out_of_range, want.out_of_range);
         end
      end
   end

   // ---------------------------------------------------------------
   // sequence: reset, directed words, random phases, drain, verdict
   // ---------------------------------------------------------------
   initial begin
      longint cnt_max;
      longint last_a;
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = '0;
      req_day_a      = '0;
      req_month_a    = '0;
      req_year_a     = '0;
      req_hour_a     = '0;
      req_minute_a   = '0;
      req_second_a   = '0;
      req_day_b      = '0;
      req_month_b    = '0;
      req_year_b     = '0;
      req_time_b     = '0;
      req_amount     = '0;
      mismatch_count = 0;
      sender_idle_pct = IDLE_PCT[0];
      span_secs = datetime_to_secs(1, 1, MAX_YEAR + 1, 0);
      cnt_max   = (longint'(1) <<< 33) - 1;
      last_a    = span_secs - 1;

      // to_seconds: epoch, last second, every field at its maximum
      // (count saturates high), all-zero date (day zero is minus one day)
      request_q.push_back(make_word(FUNC_TO_SECONDS, 1, 1, MIN_YEAR, 0, 0, 0,
                                    0, 0, 0, 0, 0));
      request_q.push_back(make_word(FUNC_TO_SECONDS, 31, 12, MAX_YEAR, 23, 59, 59,
                                    0, 0, 0, 0, 0));
      request_q.push_back(make_word(FUNC_TO_SECONDS, 31, 15, 2047, 31, 63, 63,
                                    0, 0, 0, 0, 0));
      request_q.push_back(make_word(FUNC_TO_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // from_seconds: both range edges, just outside each, amount extremes, leap day
      request_q.push_back(make_word(FUNC_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      request_q.push_back(make_word(FUNC_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1));
      request_q.push_back(make_word(FUNC_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                    last_a));
      request_q.push_back(make_word(FUNC_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                    span_secs));
      request_q.push_back(make_word(FUNC_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                    cnt_max));
      request_q.push_back(make_word(FUNC_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                    -cnt_max - 1));
      request_q.push_back(make_word(FUNC_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                    datetime_to_secs(29, 2, 2000, 12 * HOUR_SECS)));
      // add: past the last second, across february in a century and a leap century
      request_q.push_back(make_word(FUNC_ADD, 31, 12, MAX_YEAR, 23, 59, 59,
                                    0, 0, 0, 0, 1));
      request_q.push_back(make_word(FUNC_ADD, 28, 2, 1900, 12, 0, 0, 0, 0, 0, 0,
                                    DAY_SECS));
      request_q.push_back(make_word(FUNC_ADD, 28, 2, 2000, 12, 0, 0, 0, 0, 0, 0,
                                    DAY_SECS));
      request_q.push_back(make_word(FUNC_ADD, 1, 1, MIN_YEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      // subtract: before the epoch, negative offset past the end, back into a leap day
      request_q.push_back(make_word(FUNC_SUBTRACT, 1, 1, MIN_YEAR, 0, 0, 0,
                                    0, 0, 0, 0, 1));
      request_q.push_back(make_word(FUNC_SUBTRACT, 31, 12, MAX_YEAR, 23, 59, 59,
                                    0, 0, 0, 0, -1));
      request_q.push_back(make_word(FUNC_SUBTRACT, 1, 3, 1904, 0, 0, 0, 0, 0, 0, 0, 1));
      // compare: equal, a one second earlier, a one second later
      request_q.push_back(make_word(FUNC_COMPARE, 15, 6, 1999, 10, 20, 30,
                                    15, 6, 1999, 37230, 0));
      request_q.push_back(make_word(FUNC_COMPARE, 15, 6, 1999, 10, 20, 30,
                                    15, 6, 1999, 37231, 0));
      request_q.push_back(make_word(FUNC_COMPARE, 15, 6, 1999, 10, 20, 30,
                                    15, 6, 1999, 37229, 0));
      // duration: full span both ways, and saturation low with wild fields
      request_q.push_back(make_word(FUNC_DURATION, 1, 1, MIN_YEAR, 0, 0, 0,
                                    31, 12, MAX_YEAR, DAY_SECS - 1, 0));
      request_q.push_back(make_word(FUNC_DURATION, 31, 12, MAX_YEAR, 23, 59, 59,
                                    1, 1, MIN_YEAR, 0, 0));
      request_q.push_back(make_word(FUNC_DURATION, 31, 15, 2047, 31, 63, 63,
                                    0, 0, 0, 0, 0));
      // spare op codes give an all-zero word
      request_q.push_back(make_word(FUNC_SPARE_6, 15, 6, 1999, 10, 20, 30,
                                    15, 6, 1999, 37230, 12345));
      request_q.push_back(make_word(FUNC_SPARE_7, 31, 15, 2047, 31, 63, 63,
                                    31, 15, 2047, 131071, -1));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // random words in phases of different sender idling
      for (int p = 0; p < PHASES; p++) begin
         sender_idle_pct = IDLE_PCT[p];
         for (int i = 0; i < WORDS_PER_PHASE; i++) request_q.push_back(random_word());
         while (request_q.size() != 0) @(posedge clock);
      end

      // drain, then watch for stray responses a little longer
      while (request_q.size() != 0 || start || conversion_q.size() != 0) @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("datetime_seconds_converter_core: match");
      end else begin
         $display("datetime_seconds_converter_core: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #TIMEOUT_NS;
      $display("timeout with %0d words unsent and %0d responses pending",
               request_q.size(), conversion_q.size());
      $display("datetime_seconds_converter_core: mismatch");
      $finish;
   end

endmodule
